// ===== sv/bfi_pkg.sv =====
// shared types, command codes and status codes of the interpreter core
// no dependencies
package bfi_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QIN   = 2'd1,
        OP_RUN   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        C_RIGHT = 3'd0,
        C_LEFT  = 3'd1,
        C_INC   = 3'd2,
        C_DEC   = 3'd3,
        C_OUT   = 3'd4,
        C_IN    = 3'd5,
        C_OPEN  = 3'd6,
        C_CLOSE = 3'd7
    } t_cmd;

    localparam logic [2:0] ST_FINISHED  = 3'd0;
    localparam logic [2:0] ST_STEP_LIM  = 3'd1;
    localparam logic [2:0] ST_LOOP_OVF  = 3'd2;
    localparam logic [2:0] ST_UNMATCHED = 3'd3;
    localparam logic [2:0] ST_OUT_CAP   = 3'd4;
    localparam logic [2:0] ST_PROG_FULL = 3'd5;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        t_op        op;
        logic       is_cmd;
        t_cmd       code;
        logic [7:0] data;
    } t_q_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_FETCH,
        S_EXEC,
        S_SKIP,
        S_SKIPX,
        S_DONE
    } t_bstate;

    function automatic t_q_entry classify(input t_op op, input logic [7:0] b);
        t_q_entry e;
        e.op     = op;
        e.data   = b;
        e.is_cmd = 1'b1;
        e.code   = C_RIGHT;
        case (b)
            8'h3E: e.code = C_RIGHT;
            8'h3C: e.code = C_LEFT;
            8'h2B: e.code = C_INC;
            8'h2D: e.code = C_DEC;
            8'h2E: e.code = C_OUT;
            8'h2C: e.code = C_IN;
            8'h5B: e.code = C_OPEN;
            8'h5D: e.code = C_CLOSE;
            default: e.is_cmd = 1'b0;
        endcase
        return e;
    endfunction

endpackage

// ===== sv/bfi_front.sv =====
// front end: accepts input items and classifies program bytes into command codes
// depends on bfi_pkg
module bfi_front (
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_data_byte,
    input  logic               i_q_full,
    output logic               o_q_push,
    output bfi_pkg::t_q_entry  o_q_entry
);
    import bfi_pkg::*;

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;
    assign o_q_entry  = classify(t_op'(i_operation), i_data_byte);

endmodule

// ===== sv/bfi_queue.sv =====
// short fifo of classified items between front end and executor
// depends on bfi_pkg
module bfi_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bfi_pkg::t_q_entry  i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output bfi_pkg::t_q_entry  o_entry
);
    import bfi_pkg::*;

    t_q_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     r_wp, r_rp;
    logic [QUEUE_AW:0]       r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/bfi_back.sv =====
// executor: program, input queue, tape and loop stack memories plus the run sequencer
// depends on bfi_pkg
module bfi_back #(
    parameter int CELLS       = 16,
    parameter int PROG_DEPTH  = 1024,
    parameter int LOOP_DEPTH  = 16,
    parameter int INPUT_DEPTH = 64,
    parameter int OUT_MAX     = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_step_limit,
    input  logic               i_q_valid,
    input  bfi_pkg::t_q_entry  i_q_entry,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_kind,
    output logic [7:0]         o_out_byte,
    output logic [2:0]         o_status,
    output logic [31:0]        o_steps_used,
    output logic               o_last
);
    import bfi_pkg::*;

    localparam int PW   = $clog2(PROG_DEPTH);
    localparam int LENW = $clog2(PROG_DEPTH + 1);
    localparam int CW   = $clog2(CELLS);
    localparam int LW   = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
    localparam int DW   = $clog2(LOOP_DEPTH + 1);
    localparam int IW   = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
    localparam int ICW  = $clog2(INPUT_DEPTH + 1);
    localparam int NW   = $clog2(OUT_MAX + 1);

    // memories
    logic [2:0]       m_prog  [PROG_DEPTH];
    logic [7:0]       m_inq   [INPUT_DEPTH];
    logic [7:0]       m_tape  [CELLS];
    logic [PW-1:0]    m_stack [LOOP_DEPTH];

    t_bstate          r_state, n_state;
    logic [LENW-1:0]  r_len, n_len;
    logic             r_povf, n_povf;
    logic [ICW-1:0]   r_icnt, n_icnt, r_rpos, n_rpos;
    logic [LENW-1:0]  r_pc, n_pc, r_j, n_j, r_nest, n_nest;
    logic [CW-1:0]    r_dp, n_dp, r_ca, n_ca;
    logic [DW-1:0]    r_depth, n_depth;
    logic [31:0]      r_steps, n_steps;
    logic [NW-1:0]    r_nout, n_nout;
    logic [2:0]       r_stat, n_stat;

    // registered memory reads
    logic [2:0]       r_pcode;
    logic [7:0]       r_cell, r_inb;
    logic [PW-1:0]    r_top;

    // output register
    logic             r_ov, r_kind, r_last;
    logic [7:0]       r_ob;
    logic [2:0]       r_st;
    logic [31:0]      r_su;

    logic             out_free, emit, at_end, lim_hit, skip_end;
    logic             stop_out, stop_ovf, stop_unm, cell_nz;
    logic [DW-1:0]    depth_m1;
    logic [LENW-1:0]  prog_raddr;
    logic             prog_re, prog_we, inq_we, tape_we, stack_we;
    logic [CW-1:0]    tape_waddr;
    logic [7:0]       tape_wdata;
    t_cmd             cmd;

    assign cmd      = t_cmd'(r_pcode);
    assign out_free = !r_ov || !i_out_stall;
    assign at_end   = (r_pc >= r_len);
    assign skip_end = (r_j >= r_len);
    assign lim_hit  = ((i_step_limit != '0) && (r_steps >= i_step_limit)) || (&r_steps);
    assign cell_nz  = (r_cell != '0);
    assign depth_m1 = r_depth - DW'(1);
    assign stop_out = (cmd == C_OUT) && (r_nout >= NW'(OUT_MAX));
    assign stop_ovf = (cmd == C_OPEN) && cell_nz && (r_depth >= DW'(LOOP_DEPTH));
    assign stop_unm = (cmd == C_CLOSE) && (r_depth == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_q_entry.op == OP_RUN) begin
                    n_state = r_povf ? S_DONE : S_CLR;
                end
            end
            S_CLR: begin
                if (r_ca == CW'(CELLS - 1)) n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = (at_end || lim_hit) ? S_DONE : S_EXEC;
            end
            S_EXEC: begin
                if (stop_out || stop_ovf || stop_unm) begin
                    n_state = S_DONE;
                end else if (cmd == C_OUT && !out_free) begin
                    n_state = S_EXEC;
                end else if (cmd == C_OPEN && !cell_nz) begin
                    n_state = S_SKIP;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_SKIP: begin
                n_state = skip_end ? S_DONE : S_SKIPX;
            end
            S_SKIPX: begin
                if (cmd == C_CLOSE && r_nest == LENW'(1)) n_state = S_FETCH;
                else n_state = S_SKIP;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_len = r_len;     n_povf = r_povf;   n_icnt = r_icnt;   n_rpos = r_rpos;
        n_pc = r_pc;       n_j = r_j;         n_nest = r_nest;   n_dp = r_dp;
        n_ca = r_ca;       n_depth = r_depth; n_steps = r_steps; n_nout = r_nout;
        n_stat = r_stat;
        o_q_pop = 1'b0;    emit = 1'b0;
        prog_we = 1'b0;    inq_we = 1'b0;     tape_we = 1'b0;    stack_we = 1'b0;
        prog_re = 1'b0;    prog_raddr = r_pc;
        tape_waddr = r_dp; tape_wdata = '0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    case (i_q_entry.op)
                        OP_LOAD: begin
                            if (i_q_entry.is_cmd) begin
                                if (r_len < LENW'(PROG_DEPTH)) begin
                                    prog_we = 1'b1;
                                    n_len   = r_len + 1'b1;
                                end else begin
                                    n_povf = 1'b1;
                                end
                            end
                        end
                        OP_QIN: begin
                            if (r_icnt < ICW'(INPUT_DEPTH)) begin
                                inq_we = 1'b1;
                                n_icnt = r_icnt + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_len = '0; n_povf = 1'b0; n_icnt = '0; n_rpos = '0;
                        end
                        default: begin
                            // run: fresh tape, pointer, stack and counters
                            n_pc = '0; n_dp = '0; n_ca = '0; n_depth = '0;
                            n_steps = '0; n_nout = '0;
                            n_stat = r_povf ? ST_PROG_FULL : ST_FINISHED;
                        end
                    endcase
                end
            end
            S_CLR: begin
                tape_we    = 1'b1;
                tape_waddr = r_ca;
                n_ca       = r_ca + 1'b1;
            end
            S_FETCH: begin
                if (at_end) begin
                    n_stat = (r_depth != '0) ? ST_UNMATCHED : ST_FINISHED;
                end else if (lim_hit) begin
                    n_stat = ST_STEP_LIM;
                end else begin
                    prog_re = 1'b1;
                end
            end
            S_EXEC: begin
                if (stop_out) begin
                    n_stat = ST_OUT_CAP;
                end else if (stop_ovf) begin
                    n_stat = ST_LOOP_OVF;
                end else if (stop_unm) begin
                    n_stat = ST_UNMATCHED;
                end else if (!(cmd == C_OUT && !out_free)) begin
                    n_steps = r_steps + 1'b1;
                    n_pc    = r_pc + 1'b1;
                    case (cmd)
                        C_RIGHT: n_dp = (r_dp == CW'(CELLS - 1)) ? '0 : r_dp + 1'b1;
                        C_LEFT:  n_dp = (r_dp == '0) ? CW'(CELLS - 1) : r_dp - 1'b1;
                        C_INC: begin
                            tape_we = 1'b1; tape_wdata = r_cell + 8'd1;
                        end
                        C_DEC: begin
                            tape_we = 1'b1; tape_wdata = r_cell - 8'd1;
                        end
                        C_OUT: begin
                            emit   = 1'b1;
                            n_nout = r_nout + 1'b1;
                        end
                        C_IN: begin
                            tape_we = 1'b1;
                            if (r_rpos < r_icnt) begin
                                tape_wdata = r_inb;
                                n_rpos     = r_rpos + 1'b1;
                            end
                        end
                        C_OPEN: begin
                            if (cell_nz) begin
                                stack_we = 1'b1;
                                n_depth  = r_depth + 1'b1;
                            end else begin
                                n_j    = r_pc + 1'b1;
                                n_nest = LENW'(1);
                            end
                        end
                        default: begin
                            if (cell_nz) n_pc = LENW'(r_top) + 1'b1;
                            else n_depth = depth_m1;
                        end
                    endcase
                end
            end
            S_SKIP: begin
                prog_raddr = r_j;
                if (skip_end) n_stat = ST_UNMATCHED;
                else prog_re = 1'b1;
            end
            S_SKIPX: begin
                n_j = r_j + 1'b1;
                if (cmd == C_OPEN) begin
                    n_nest = r_nest + 1'b1;
                end else if (cmd == C_CLOSE) begin
                    n_nest = r_nest - 1'b1;
                    if (r_nest == LENW'(1)) n_pc = r_j + 1'b1;
                end
            end
            S_DONE: begin
                emit = out_free;
            end
            default: ;
        endcase
    end

    // program store
    always_ff @(posedge i_clk) begin
        if (prog_we) m_prog[r_len[PW-1:0]] <= i_q_entry.code;
        if (prog_re) r_pcode <= m_prog[prog_raddr[PW-1:0]];
    end

    // input byte store
    always_ff @(posedge i_clk) begin
        if (inq_we) m_inq[r_icnt[IW-1:0]] <= i_q_entry.data;
        if (r_state == S_FETCH && r_rpos < r_icnt) r_inb <= m_inq[r_rpos[IW-1:0]];
    end

    // tape
    always_ff @(posedge i_clk) begin
        if (tape_we) m_tape[tape_waddr] <= tape_wdata;
        if (r_state == S_FETCH) r_cell <= m_tape[r_dp];
    end

    // loop stack
    always_ff @(posedge i_clk) begin
        if (stack_we) m_stack[r_depth[LW-1:0]] <= r_pc[PW-1:0];
        if (r_state == S_FETCH && r_depth != '0) r_top <= m_stack[depth_m1[LW-1:0]];
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= (r_state == S_DONE) ? KIND_STATUS : KIND_BYTE;
            r_last <= (r_state == S_DONE);
            r_ob   <= (r_state == S_DONE) ? 8'd0 : r_cell;
            r_st   <= (r_state == S_DONE) ? r_stat : ST_FINISHED;
            r_su   <= (r_state == S_DONE) ? r_steps : r_steps + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;  r_povf <= 1'b0; r_icnt <= '0; r_rpos <= '0;
            r_pc    <= '0;  r_j    <= '0;   r_nest <= '0; r_dp   <= '0;
            r_ca    <= '0;  r_depth <= '0;  r_steps <= '0; r_nout <= '0;
            r_stat  <= ST_FINISHED;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;  r_povf <= n_povf;   r_icnt  <= n_icnt;  r_rpos <= n_rpos;
            r_pc    <= n_pc;   r_j    <= n_j;      r_nest  <= n_nest;  r_dp   <= n_dp;
            r_ca    <= n_ca;   r_depth <= n_depth; r_steps <= n_steps; r_nout <= n_nout;
            r_stat  <= n_stat;
            if (emit) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_kind       = r_kind;
    assign o_out_byte   = r_ob;
    assign o_status     = r_st;
    assign o_steps_used = r_su;
    assign o_last       = r_last;

endmodule

// ===== sv/bf_interpreter_core_unit.sv =====
// top level of the interpreter core: front end, item queue, executor, step limit register
// depends on bfi_pkg, bfi_front, bfi_queue, bfi_back
//
// load, queue-byte and clear items are taken at one per cycle while the executor is idle; a
// short queue lets the front keep accepting while the executor is busy. a run item leaves
// the queue, then the tape is zeroed one cell per cycle, then each executed command passes
// through a fetch (program memory and tape read), then an execute step; a '[' on a zero cell
// adds a read and a scan step per program entry scanned while skipping forward, and ending
// the run takes the check that stops it, then the status write; output stalls add to that. a
// run with the program full goes straight to its status item. every run returns one status
// item with last set, preceded by one byte item per executed '.', at most OUT_MAX. the single
// configuration register is step_limit (reset 1000000, zero means no limit) and must only be
// written while no run is in progress.
module bf_interpreter_core_unit #(
    parameter int CELLS       = 16,
    parameter int PROG_DEPTH  = 1024,
    parameter int LOOP_DEPTH  = 16,
    parameter int INPUT_DEPTH = 64,
    parameter int OUT_MAX     = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_data_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_status,
    output logic [31:0] o_steps_used,
    output logic        o_last,
    // step limit write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import bfi_pkg::*;

    logic        q_full, q_push, q_pop, q_valid;
    t_q_entry    q_in, q_out;
    logic [31:0] r_step_limit;

    // step limit register, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= 32'd1000000;
        end else if (i_cfg_valid) begin
            r_step_limit <= i_cfg_data;
        end
    end

    bfi_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_entry   (q_in)
    );

    bfi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    bfi_back #(
        .CELLS       (CELLS),
        .PROG_DEPTH  (PROG_DEPTH),
        .LOOP_DEPTH  (LOOP_DEPTH),
        .INPUT_DEPTH (INPUT_DEPTH),
        .OUT_MAX     (OUT_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_limit (r_step_limit),
        .i_q_valid    (q_valid),
        .i_q_entry    (q_out),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_status     (o_status),
        .o_steps_used (o_steps_used),
        .o_last       (o_last)
    );

endmodule

// ===== sv/bfi_checker.sv =====
// port-level checks on the result channel of the interpreter core, bound to the top level
// depends on bf_interpreter_core_unit
module bfi_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_kind,
    input logic [7:0]  o_out_byte,
    input logic [2:0]  o_status,
    input logic [31:0] o_steps_used,
    input logic        o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_steps_used) && $stable(o_kind))
        else $error("stalled result changed");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_last == o_kind)
        else $error("last flag differs from kind");

    a_byte_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kind |-> o_status == 3'd0)
        else $error("byte item with nonzero status");

    a_status_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind |-> o_out_byte == 8'd0 && o_status <= 3'd5)
        else $error("bad status item");

endmodule

bind bf_interpreter_core_unit bfi_port_checker u_bfi_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_kind       (o_kind),
    .o_out_byte   (o_out_byte),
    .o_status     (o_status),
    .o_steps_used (o_steps_used),
    .o_last       (o_last)
);
